// ===== design/kli_pkg.sv =====
// Shared widths, codes and types for the keyframe linear interpolator.
`timescale 1ns / 1ps

package kli_pkg;

    localparam int KEY_W    = 32;   // keyframe / result value, Q16.16
    localparam int POS_W    = 18;   // position, Q2.16
    localparam int CNT_W    = 5;    // key_count register
    localparam int KIDX_W   = 4;    // key_index field
    localparam int V_W      = 24;   // position * (count - 1)
    localparam int SEG_W    = V_W - 16;
    localparam int FRAC_W   = 18;   // -65535 .. 65536
    localparam int DIFF_W   = KEY_W + 1;
    localparam int PROD_W   = DIFF_W + FRAC_W;
    localparam int SUM_W    = PROD_W - 16 + 1;

    localparam int DEFAULT_MAX_KEYS = 16;

    localparam logic [CNT_W-1:0]         KEY_COUNT_RESET = CNT_W'(2);
    localparam logic signed [FRAC_W-1:0] FRAC_ONE        = FRAC_W'(65536);

    typedef enum logic [0:0] {
        ACT_WRITE = 1'b0,
        ACT_EVAL  = 1'b1
    } action_t;

    // Control that rides alongside the two keyframes into the lerp stages.
    typedef struct packed {
        logic                     pass;
        logic signed [KEY_W-1:0]  pass_value;
        logic signed [FRAC_W-1:0] frac;
    } lerp_req_t;

endpackage

// ===== design/kli_if.sv =====
// Channel interfaces: command items, results and the key_count write port.
`timescale 1ns / 1ps

interface kli_in_if;
    import kli_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [KIDX_W-1:0]       key_index;
    logic signed [KEY_W-1:0] key_value;
    logic signed [POS_W-1:0] position;

    modport source (output valid, output action, output key_index,
                    output key_value, output position, input ready);
    modport sink   (input valid, input action, input key_index,
                    input key_value, input position, output ready);
endinterface

interface kli_out_if;
    import kli_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] value;
    logic                    saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);
endinterface

interface kli_cfg_if;
    import kli_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/keyframe_linear_interpolator.sv =====
// Top level of the piecewise-linear keyframe interpolator.
`timescale 1ns / 1ps

// Channel | Dir | Beat carries                                | Handshake
// --------+-----+---------------------------------------------+-----------
// cmd     | in  | action, key_index, key_value, position      | valid/ready
// res     | out | value, saturated (evaluate items only)      | valid/ready
// cfg     | in  | key_count (5 bits)                          | valid/ready
//
// Seven register stages, s1 to s7; an evaluate beat reaches res from s7.
// A new cmd beat can be taken every cycle while res is not stalled.
// Throughput is then one beat per cycle, set by the single table read stage.
// Write beats update the table at the read stage, in order with evaluates,
// and leave the pipe there without a result.
// Each stage advances when its successor has room, so bubbles collapse under
// a res stall; cmd.ready drops only once every stage is full.
// Reset clears valid bits and sets key_count to 2; table contents are kept.
// cfg is always ready.

module keyframe_linear_interpolator #(
    parameter int MAX_KEYS = kli_pkg::DEFAULT_MAX_KEYS
) (
    input  logic       clk,
    input  logic       rst_n,
    kli_in_if.sink     cmd,
    kli_out_if.source  res,
    kli_cfg_if.sink    cfg
);
    import kli_pkg::*;

    localparam int ADDR_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_CAP = (MAX_KEYS > 31) ? 31 : MAX_KEYS;
    localparam logic [CNT_W-1:0] CntCapVal = CNT_W'(CNT_CAP);

    // configuration
    logic [CNT_W-1:0] key_count_reg;
    logic [CNT_W-1:0] cnt_eff;

    // stage 1: accepted beat
    logic                    s1_valid_reg;
    logic                    s1_action_reg;
    logic [KIDX_W-1:0]       s1_key_index_reg;
    logic signed [KEY_W-1:0] s1_key_value_reg;
    logic signed [POS_W-1:0] s1_position_reg;
    // stage 2: scaled position
    logic                    s2_valid_reg;
    logic                    s2_action_reg;
    logic [KIDX_W-1:0]       s2_key_index_reg;
    logic signed [KEY_W-1:0] s2_key_value_reg;
    logic signed [V_W-1:0]   s2_v_reg;
    logic [CNT_W-1:0]        s2_cm1_reg;
    logic                    s2_pass_reg;
    logic signed [KEY_W-1:0] s2_pass_value_reg;
    // stage 3: segment and fraction
    logic                     s3_valid_reg;
    logic                     s3_action_reg;
    logic [KIDX_W-1:0]        s3_key_index_reg;
    logic signed [KEY_W-1:0]  s3_key_value_reg;
    logic [ADDR_W-1:0]        s3_idx_reg;
    logic signed [FRAC_W-1:0] s3_frac_reg;
    logic                     s3_pass_reg;
    logic signed [KEY_W-1:0]  s3_pass_value_reg;
    // stage 4: table read out
    logic      s4_valid_reg;
    lerp_req_t s4_req_reg;

    logic en1, en2, en3, en4;
    logic lerp_ready;

    logic                     pass_next;
    logic [CNT_W-1:0]         cm1_next;
    logic [SEG_W-1:0]         seg_pos;
    logic [ADDR_W-1:0]        idx_next;
    logic signed [FRAC_W-1:0] frac_next;
    logic                     s3_is_eval;
    logic                     tbl_wr_en;

    logic signed [KEY_W-1:0] k0, k1;

    // ---- configuration port ----
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= KEY_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            key_count_reg <= cfg.data;
        end
    end

    assign cnt_eff = (key_count_reg > CntCapVal) ? CntCapVal : key_count_reg;

    // ---- stage enables (per-stage ready chain) ----
    assign en4       = !s4_valid_reg || lerp_ready;
    assign en3       = !s3_valid_reg || en4;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign cmd.ready = en1;

    // ---- stage 2 logic: scale by count-1 ----
    // With fewer than two keys the item passes position through; cm1 is
    // forced to 1 so the segment math stays in range.
    assign pass_next = (cnt_eff < CNT_W'(2));
    assign cm1_next  = pass_next ? CNT_W'(1) : (cnt_eff - CNT_W'(1));

    // ---- stage 3 logic: segment index and fraction ----
    assign seg_pos = s2_v_reg[V_W-1:16];

    always_comb
    begin
        if (!s2_v_reg[V_W-1])
        begin
            if (seg_pos >= SEG_W'(s2_cm1_reg))
            begin
                // past the last segment: last keyframe exactly
                idx_next  = ADDR_W'(s2_cm1_reg - CNT_W'(1));
                frac_next = FRAC_ONE;
            end
            else
            begin
                idx_next  = ADDR_W'(seg_pos);
                frac_next = FRAC_W'({1'b0, s2_v_reg[15:0]});
            end
        end
        else if (s2_v_reg > -V_W'(65536))
        begin
            // small negative: truncates to segment 0, extrapolates
            idx_next  = '0;
            frac_next = FRAC_W'(s2_v_reg);
        end
        else
        begin
            idx_next  = '0;
            frac_next = '0;
        end
    end

    // ---- stage 4: table access, in item order ----
    assign s3_is_eval = (s3_action_reg == ACT_EVAL);
    assign tbl_wr_en  = en4 && s3_valid_reg && !s3_is_eval
                        && (32'(s3_key_index_reg) < MAX_KEYS);

    kli_key_table #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (tbl_wr_en),
        .wr_addr  (ADDR_W'(s3_key_index_reg)),
        .wr_data  (s3_key_value_reg),
        .rd_en    (en4),
        .rd_addr0 (s3_idx_reg),
        .rd_addr1 (s3_idx_reg + ADDR_W'(1)),
        .rd_data0 (k0),
        .rd_data1 (k1)
    );

    // ---- valid bits ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= cmd.valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg && s3_is_eval;
        end
    end

    // ---- payload ----
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_action_reg    <= cmd.action;
            s1_key_index_reg <= cmd.key_index;
            s1_key_value_reg <= cmd.key_value;
            s1_position_reg  <= cmd.position;
        end
        if (en2)
        begin
            s2_action_reg     <= s1_action_reg;
            s2_key_index_reg  <= s1_key_index_reg;
            s2_key_value_reg  <= s1_key_value_reg;
            s2_v_reg          <= V_W'(s1_position_reg) * V_W'(cm1_next);
            s2_cm1_reg        <= cm1_next;
            s2_pass_reg       <= pass_next;
            s2_pass_value_reg <= KEY_W'(s1_position_reg);
        end
        if (en3)
        begin
            s3_action_reg     <= s2_action_reg;
            s3_key_index_reg  <= s2_key_index_reg;
            s3_key_value_reg  <= s2_key_value_reg;
            s3_idx_reg        <= idx_next;
            s3_frac_reg       <= frac_next;
            s3_pass_reg       <= s2_pass_reg;
            s3_pass_value_reg <= s2_pass_value_reg;
        end
        if (en4)
        begin
            s4_req_reg.pass       <= s3_pass_reg;
            s4_req_reg.pass_value <= s3_pass_value_reg;
            s4_req_reg.frac       <= s3_frac_reg;
        end
    end

    // ---- lerp back end and result register ----
    kli_lerp u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s4_valid_reg),
        .req_ready (lerp_ready),
        .req       (s4_req_reg),
        .k0        (k0),
        .k1        (k1),
        .res       (res)
    );

    // ---- assertions ----
    // write beats leave the pipe at the table stage
    a_write_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (en4 && s3_valid_reg && !s3_is_eval) |=> !s4_valid_reg)
        else $error("write beat moved past table stage");

    // fraction stays within (-1, 1] in Q.16
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_frac_reg <= FRAC_ONE && s3_frac_reg > -FRAC_ONE))
        else $error("fraction out of range");

    // both keyframes read lie inside the active table
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_is_eval && !s3_pass_reg)
        |-> ((32'(s3_idx_reg) + 32'd1) < 32'(cnt_eff)))
        else $error("segment index beyond key count");

    // back pressure only once stages 1 to 4 all hold a beat
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg))
        else $error("cmd stalled with an empty stage");

endmodule

// ===== design/kli_key_table.sv =====
// Keyframe memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module kli_key_table #(
    parameter int DEPTH  = kli_pkg::DEFAULT_MAX_KEYS,
    parameter int ADDR_W = 4
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic signed [kli_pkg::KEY_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [ADDR_W-1:0]                rd_addr0,
    input  logic [ADDR_W-1:0]                rd_addr1,
    output logic signed [kli_pkg::KEY_W-1:0] rd_data0,
    output logic signed [kli_pkg::KEY_W-1:0] rd_data1
);
    import kli_pkg::*;

    logic signed [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule

// ===== design/kli_lerp.sv =====
// Lerp back end: difference, scale by fraction, add and saturate, or pass a value through.
`timescale 1ns / 1ps

module kli_lerp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  kli_pkg::lerp_req_t               req,
    input  logic signed [kli_pkg::KEY_W-1:0] k0,
    input  logic signed [kli_pkg::KEY_W-1:0] k1,
    kli_out_if.source                        res
);
    import kli_pkg::*;

    // stage 5: difference
    logic                     s5_valid_reg;
    logic signed [DIFF_W-1:0] s5_diff_reg;
    logic signed [KEY_W-1:0]  s5_k0_reg;
    lerp_req_t                s5_req_reg;
    // stage 6: product
    logic                     s6_valid_reg;
    logic signed [PROD_W-1:0] s6_prod_reg;
    logic signed [KEY_W-1:0]  s6_k0_reg;
    logic                     s6_pass_reg;
    logic signed [KEY_W-1:0]  s6_pass_value_reg;
    // stage 7: result register
    logic                     s7_valid_reg;
    logic signed [KEY_W-1:0]  s7_value_reg;
    logic                     s7_sat_reg;

    logic en5, en6, en7;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [KEY_W-1:0] value_next;
    logic                    sat_next;

    assign en7       = !s7_valid_reg || res.ready;
    assign en6       = !s6_valid_reg || en7;
    assign en5       = !s5_valid_reg || en6;
    assign req_ready = en5;

    always_comb
    begin
        sum_next = SUM_W'(s6_k0_reg) + SUM_W'($signed(s6_prod_reg[PROD_W-1:16]));
        if (s6_pass_reg)
        begin
            value_next = s6_pass_value_reg;
            sat_next   = 1'b0;
        end
        else if (sum_next > SUM_W'(32'sh7FFF_FFFF))
        begin
            value_next = 32'sh7FFF_FFFF;
            sat_next   = 1'b1;
        end
        else if (sum_next < -SUM_W'(33'sh0_8000_0000))
        begin
            value_next = 32'sh8000_0000;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = sum_next[KEY_W-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (en5) s5_valid_reg <= req_valid;
            if (en6) s6_valid_reg <= s5_valid_reg;
            if (en7) s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_diff_reg <= DIFF_W'(k1) - DIFF_W'(k0);
            s5_k0_reg   <= k0;
            s5_req_reg  <= req;
        end
        if (en6)
        begin
            s6_prod_reg       <= PROD_W'(s5_diff_reg) * PROD_W'(s5_req_reg.frac);
            s6_k0_reg         <= s5_k0_reg;
            s6_pass_reg       <= s5_req_reg.pass;
            s6_pass_value_reg <= s5_req_reg.pass_value;
        end
        if (en7)
        begin
            s7_value_reg <= value_next;
            s7_sat_reg   <= sat_next;
        end
    end

    assign res.valid     = s7_valid_reg;
    assign res.value     = s7_value_reg;
    assign res.saturated = s7_sat_reg;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the keyframe linear interpolator.
`timescale 1ns / 1ps

module testbench;
    import kli_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int DRAIN_CYCLES = 12;    // seven stages plus margin for write beats
    localparam int STALL_LIMIT  = 1000;  // cycles with no beat on any channel
    localparam int LONG_HOLD    = 120;   // res back-pressure burst, in cycles
    localparam int TABLE_DEPTH  = DEFAULT_MAX_KEYS;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam int                      POS_ONE = 65536;

    typedef struct {
        action_t                 action;
        logic [KIDX_W-1:0]       key_index;
        logic signed [KEY_W-1:0] key_value;
        logic signed [POS_W-1:0] position;
    } cmd_beat_t;

    typedef struct {
        logic signed [KEY_W-1:0] value;
        logic                    saturated;
    } lerp_result_t;

    logic clk;
    logic rst_n;

    kli_in_if  cmd_bus ();
    kli_out_if res_bus ();
    kli_cfg_if cfg_bus ();

    keyframe_linear_interpolator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // Shadow state of the block: keyframe table and key_count register.
    logic signed [KEY_W-1:0] key_shadow [TABLE_DEPTH];
    logic [CNT_W-1:0]        key_count_q;

    cmd_beat_t    pending_beats   [$];
    lerp_result_t expected_values [$];

    int error_count;
    int items_queued;
    int in_gap_max;
    int out_gap_max;
    int hold_req;
    int idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: the value an evaluate beat must return, given the shadow
    // table and key_count at the moment the beat is taken.
    // ------------------------------------------------------------------
    function automatic lerp_result_t lerp_predict(logic signed [POS_W-1:0] pos);
        lerp_result_t res;
        longint       cnt;
        longint       v;
        longint       seg;
        longint       frac;
        longint       k0;
        longint       k1;
        longint       r;
        cnt = (key_count_q > TABLE_DEPTH) ? TABLE_DEPTH : key_count_q;
        res.saturated = 1'b0;
        // Fewer than two keyframes: position comes back sign-extended.
        if (cnt < 2)
        begin
            res.value = KEY_W'(pos);
            return res;
        end
        v    = longint'(pos) * (cnt - 1);
        seg  = v / POS_ONE;              // truncates toward zero
        frac = v - seg * POS_ONE;        // negative for small negative v
        // Past the last segment: pin to the last keyframe exactly.
        if (seg >= cnt - 1)
        begin
            seg  = cnt - 2;
            frac = POS_ONE;
        end
        // Whole segments below zero: pin to the first keyframe.
        if (seg < 0)
        begin
            seg  = 0;
            frac = 0;
        end
        k0 = key_shadow[seg];
        k1 = key_shadow[seg + 1];
        r  = k0 + (((k1 - k0) * frac) >>> 16);   // floor shift
        if (r > longint'(KEY_MAX))
        begin
            r = longint'(KEY_MAX);
            res.saturated = 1'b1;
        end
        else if (r < longint'(KEY_MIN))
        begin
            r = longint'(KEY_MIN);
            res.saturated = 1'b1;
        end
        res.value = r[KEY_W-1:0];
        return res;
    endfunction

    // A beat taken by the block: writes go to the shadow table, evaluates
    // leave an expected result behind.
    function automatic void take_beat(cmd_beat_t b);
        if (b.action == ACT_WRITE)
            key_shadow[b.key_index] = b.key_value;
        else
            expected_values.push_back(lerp_predict(b.position));
    endfunction

    // ------------------------------------------------------------------
    // Command driver: one NBA per signal per edge; a beat stays up until
    // taken, then an idle gap drawn per beat may follow.
    // ------------------------------------------------------------------
    cmd_beat_t cur_beat;
    int        in_gap;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                take_beat(cur_beat);
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    cmd_bus.valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    cur_beat = pending_beats.pop_front();
                    cmd_bus.action    <= cur_beat.action;
                    cmd_bus.key_index <= cur_beat.key_index;
                    cmd_bus.key_value <= cur_beat.key_value;
                    cmd_bus.position  <= cur_beat.position;
                    cmd_bus.valid     <= 1'b1;
                    in_gap = $urandom_range(0, in_gap_max);
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each beat against the oldest expectation and
    // paces res.ready. A bump of hold_req starts one long stall.
    // ------------------------------------------------------------------
    int           out_wait;
    int           hold_left;
    int           hold_ack;
    lerp_result_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
            out_wait  = 0;
            hold_left = 0;
            hold_ack  = 0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: result with nothing expected: value %h sat %b",
                             $time, res_bus.value, res_bus.saturated);
                    error_count++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (res_bus.value !== want.value)
                    begin
                        $display("%0t: value mismatch: expected %h, actual %h",
                                 $time, want.value, res_bus.value);
                        error_count++;
                    end
                    if (res_bus.saturated !== want.saturated)
                    begin
                        $display("%0t: saturated mismatch: expected %b, actual %b",
                                 $time, want.saturated, res_bus.saturated);
                        error_count++;
                    end
                end
                out_wait = $urandom_range(0, out_gap_max);
            end
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (out_wait > 0)
            begin
                out_wait--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= 1'b1;
        end
    end

    // Watchdog: any beat on any channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_write(int idx, logic signed [KEY_W-1:0] val);
        cmd_beat_t b;
        b.action    = ACT_WRITE;
        b.key_index = idx[KIDX_W-1:0];
        b.key_value = val;
        b.position  = POS_W'($urandom);   // ignored on writes
        pending_beats.push_back(b);
        items_queued++;
    endtask

    task automatic push_eval(logic signed [POS_W-1:0] pos);
        cmd_beat_t b;
        b.action    = ACT_EVAL;
        b.key_index = KIDX_W'($urandom);  // ignored on evaluates
        b.key_value = KEY_W'($urandom);
        b.position  = pos;
        pending_beats.push_back(b);
        items_queued++;
    endtask

    // Sender pause: wait until every beat is in and every result is out,
    // then let write beats still in flight leave the pipe. Checked at the
    // falling edge so the driver's updates from the rising edge are settled.
    task automatic drain_pipe();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || cmd_bus.valid || expected_values.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_count(int cnt);
        @(posedge clk);
        cfg_bus.data  <= cnt[CNT_W-1:0];
        cfg_bus.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        key_count_q = cnt[CNT_W-1:0];
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return KEY_W'(int'($urandom_range(0, 2000)) - 1000);
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Positions aimed at segment edges, the clamps and the small negative
    // band that extrapolates below the first keyframe.
    function automatic logic signed [POS_W-1:0] pick_position();
        int segs;
        int lim;
        int k;
        segs = ((key_count_q > TABLE_DEPTH) ? TABLE_DEPTH : key_count_q) - 1;
        lim  = (segs >= 1) ? (POS_ONE / segs) : 100;
        case ($urandom_range(0, 9))
            0, 1:    return POS_W'($urandom);
            2, 3, 4: return POS_W'($urandom_range(0, POS_ONE));
            5:       return -POS_W'($urandom_range(1, lim));
            6:
            begin
                k = (segs >= 1) ? $urandom_range(0, segs) : 0;
                return POS_W'((k * POS_ONE) / ((segs >= 1) ? segs : 1)
                              + int'($urandom_range(0, 2)) - 1);
            end
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       return POS_MIN;
                    1:       return POS_MAX;
                    2:       return POS_W'(POS_ONE);
                    3:       return POS_W'(POS_ONE - 1);
                    4:       return '0;
                    default: return '1;
                endcase
            end
            default: return POS_W'($urandom_range(POS_ONE, 131071));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase_no;
        int n;
        int sel;
        int cnt;
        cmd_bus.valid     = 1'b0;
        cmd_bus.action    = ACT_WRITE;
        cmd_bus.key_index = '0;
        cmd_bus.key_value = '0;
        cmd_bus.position  = '0;
        res_bus.ready     = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.data      = '0;
        clk          = 1'b0;
        rst_n        = 1'b0;
        error_count  = 0;
        items_queued = 0;
        in_gap_max   = 0;
        out_gap_max  = 0;
        hold_req     = 0;
        idle_cycles  = 0;
        key_count_q  = KEY_COUNT_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
            key_shadow[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fill the whole table first so no evaluate ever reads an
        // entry that was never written. Entries 0/1 hold opposite extremes.
        push_write(0, KEY_MIN);
        push_write(1, KEY_MAX);
        for (int i = 2; i < TABLE_DEPTH; i++)
            push_write(i, pick_key());
        // key_count still at its reset value of 2
        push_eval('0);
        push_eval(POS_MAX);              // above last segment
        push_eval(POS_MIN);              // whole segments below zero
        push_eval(-POS_W'(32768));       // extrapolates, clips low
        push_write(0, KEY_MAX);
        push_write(1, KEY_MIN);
        push_eval('1);                   // extrapolates, clips high
        drain_pipe();
        write_key_count(0);              // pass-through
        push_eval(POS_MIN);
        push_eval(POS_MAX);
        drain_pipe();
        write_key_count(TABLE_DEPTH);
        push_eval('1);
        drain_pipe();
        write_key_count(31);             // clamps to table depth
        push_eval(POS_W'(POS_ONE));

        // Random phases: new key_count and new pacing in each, with the
        // pipe drained before every register write.
        phase_no = 0;
        while (items_queued < ITEM_TARGET)
        begin
            drain_pipe();
            sel = $urandom_range(0, 9);
            case (sel)
                0:       cnt = $urandom_range(0, 1);
                1:       cnt = $urandom_range(TABLE_DEPTH + 1, 31);
                2:       cnt = TABLE_DEPTH;
                3:       cnt = 2;
                default: cnt = $urandom_range(2, TABLE_DEPTH);
            endcase
            write_key_count(cnt);
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            n = $urandom_range(15, 70);
            // Back-pressure bursts: res stalls long while cmd keeps coming,
            // so the pipe fills and cmd.ready drops.
            if (phase_no == 2 || phase_no == 12)
            begin
                in_gap_max = 0;
                n          = 60;
                hold_req++;
            end
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_write($urandom_range(0, TABLE_DEPTH - 1), pick_key());
                else
                    push_eval(pick_position());
            end
            phase_no++;
        end
        drain_pipe();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/kli_pkg.sv
design/kli_if.sv
design/kli_key_table.sv
design/kli_lerp.sv
design/keyframe_linear_interpolator.sv
sim/testbench.sv
